// ===== rtl/core/gaussian_blur_window_filter_assert.svh =====
// Assertion macros shared by the checker of gaussian_blur_window_filter.
// Expects signals named clk and rst in the enclosing scope.
`ifndef GAUSSIAN_BLUR_WINDOW_FILTER_ASSERT_SVH
`define GAUSSIAN_BLUR_WINDOW_FILTER_ASSERT_SVH
// same-cycle implication
`define GBWF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbwf check failed");
// next-cycle implication
`define GBWF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbwf check failed");
`endif

// ===== rtl/core/gbwf_pkg.sv =====
// Shared types and constants of the Gaussian blur window filter.
// No dependencies.
package gbwf_pkg;
  localparam int RADIUS_DEF    = 3;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int TAP_W         = 3;
  localparam int DIM_W         = 11;
  localparam int DRAIN_CYCLES  = 3;

  typedef enum logic [2:0] {
    REG_WEIGHT_CENTER = 3'd0,
    REG_WEIGHT_ONE    = 3'd1,
    REG_WEIGHT_TWO    = 3'd2,
    REG_WEIGHT_THREE  = 3'd3,
    REG_FRAME_WIDTH   = 3'd4,
    REG_FRAME_HEIGHT  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic             capture;
    logic             calc;
    logic             restart;
    logic             write;
    logic             start;
    logic             issue;
    logic [TAP_W-1:0] tap_y;
    logic [TAP_W-1:0] tap_x;
    logic             load_out;
    logic             advance;
  } dp_cmd_t;

  typedef struct packed {
    logic restart;
    logic in_frame;
    logic has_out;
    logic padding;
    logic out_free;
  } dp_status_t;
endpackage

// ===== rtl/core/gbwf_ctrl.sv =====
// Item sequencer of the Gaussian blur window filter.
// Depends on gbwf_pkg.
module gbwf_ctrl import gbwf_pkg::*; #(
  parameter int RADIUS = RADIUS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(2 * RADIUS);

  typedef enum logic [2:0] {IDLE, CALC, DECIDE, SCAN, DRAIN, EMIT} state_t;

  state_t           state, state_next;
  logic [TAP_W-1:0] ty, ty_next, tx, tx_next;
  logic [1:0]       cnt, cnt_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    state_next = state;
    ty_next    = ty;
    tx_next    = tx;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.tap_y  = ty;
    cmd.tap_x  = tx;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = CALC;
        end
      end
      CALC: begin
        cmd.calc   = 1'b1;
        state_next = DECIDE;
      end
      DECIDE: begin
        if (status.restart) begin
          cmd.restart = 1'b1;
          state_next  = CALC;
        end else if (status.in_frame && status.padding) begin
          state_next = IDLE;
        end else begin
          cmd.write = status.in_frame;
          if (status.has_out) begin
            cmd.start  = 1'b1;
            ty_next    = '0;
            tx_next    = '0;
            state_next = SCAN;
          end else begin
            cmd.advance = 1'b1;
            state_next  = IDLE;
          end
        end
      end
      SCAN: begin
        cmd.issue = 1'b1;
        if (tx == TAP_LAST) begin
          tx_next = '0;
          if (ty == TAP_LAST) begin
            cnt_next   = '0;
            state_next = DRAIN;
          end else begin
            ty_next = ty + 1'b1;
          end
        end else begin
          tx_next = tx + 1'b1;
        end
      end
      DRAIN: begin
        cnt_next = cnt + 1'b1;
        if (cnt == 2'(DRAIN_CYCLES - 1)) state_next = EMIT;
      end
      EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.advance  = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      ty    <= '0;
      tx    <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      ty    <= ty_next;
      tx    <= tx_next;
      cnt   <= cnt_next;
    end
  end
endmodule

// ===== rtl/core/gbwf_datapath.sv =====
// Datapath of the Gaussian blur window filter: registers, row store,
// window address, weight multiply and accumulate, output stage. Depends on gbwf_pkg.
module gbwf_datapath import gbwf_pkg::*; #(
  parameter int RADIUS    = RADIUS_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [23:0] in_data,
  input  logic        in_pad,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_data,
  output logic        out_last
);
  localparam int SR     = 2 * RADIUS + 2;
  localparam int DEPTH  = SR * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(SR);
  localparam int PW     = 2 * DIM_W;

  logic [15:0]        weight [4];
  logic [DIM_W-1:0]   fw, fh, w_eff, h_eff;
  logic [23:0]        pix;
  logic               pad;
  logic [DIM_W-1:0]   col, row, ox, oy;
  logic [SLOT_W-1:0]  slot;
  logic [PW-1:0]      pos_r, limit, o_pos;
  logic [PW-2:0]      total_r;
  logic [12:0]        lat_r;
  logic               last;
  logic [23:0]        mem [DEPTH];

  logic signed [12:0] ox_s;
  logic [DIM_W-1:0]   oy_c;
  logic signed [12:0] ry_s, rx_s;
  logic [DIM_W-1:0]   ry, rx, diff;
  logic [DIM_W-1:0]   slot_rd;
  logic [AW-1:0]      addr_a;
  logic [1:0]         wy_a, wx_a;
  logic               va, vb, vc;
  logic [23:0]        rdata;
  logic [31:0]        wprod;
  logic [39:0]        pr, pg, pb;
  logic [47:0]        ar, ag, ab;

  function automatic logic [7:0] round_sat(input logic [47:0] acc);
    logic [47:0] v;
    v = (acc + 48'h0000_8000_0000) >> 32;
    return (v > 48'd255) ? 8'hFF : v[7:0];
  endfunction

  always_comb begin
    if (fw == '0) w_eff = DIM_W'(1);
    else if (fw > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = fw;
    if (fh == '0) h_eff = DIM_W'(1);
    else if (fh > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = fh;
  end

  assign limit           = PW'(total_r) - PW'(1) + PW'(lat_r);
  assign o_pos           = pos_r - PW'(lat_r);
  assign status.restart  = pos_r > limit;
  assign status.in_frame = pos_r < PW'(total_r);
  assign status.has_out  = pos_r >= PW'(lat_r);
  assign status.padding  = pad;
  assign status.out_free = !out_valid || out_ready;
  assign last            = status.has_out && (o_pos == PW'(total_r) - PW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      weight[0] <= 16'hFFFF;
      weight[1] <= '0;
      weight[2] <= '0;
      weight[3] <= '0;
      fw        <= DIM_W'(800);
      fh        <= DIM_W'(600);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WEIGHT_CENTER, REG_WEIGHT_ONE, REG_WEIGHT_TWO, REG_WEIGHT_THREE:
          weight[cfg_index[1:0]] <= cfg_data;
        REG_FRAME_WIDTH:  fw <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: fh <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (cmd.restart || (cmd.advance && last)) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (cmd.advance) begin
      if (col + 1'b1 >= w_eff) begin
        col  <= '0;
        row  <= row + 1'b1;
        slot <= (slot == SLOT_W'(SR - 1)) ? '0 : slot + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // output position: step back RADIUS rows and RADIUS columns, borrowing whole rows as needed
  always_comb begin
    ox_s = $signed({2'b00, col}) - 13'(RADIUS);
    oy_c = row - DIM_W'(RADIUS);
    for (int i = 0; i < RADIUS; i++) begin
      if (ox_s < 0) begin
        ox_s = ox_s + $signed({2'b00, w_eff});
        oy_c = oy_c - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix <= {in_data[7:0], in_data[15:8], in_data[23:16]};
      pad <= in_pad;
    end
    if (cmd.calc) begin
      pos_r   <= PW'(row) * PW'(w_eff) + PW'(col);
      total_r <= (PW-1)'(w_eff) * (PW-1)'(h_eff);
      lat_r   <= 13'(RADIUS) * 13'(w_eff) + 13'(RADIUS);
    end
    if (cmd.start) begin
      ox <= ox_s[DIM_W-1:0];
      oy <= oy_c;
    end
    if (cmd.write) mem[AW'(32'(slot) * MAX_WIDTH + 32'(col))] <= pix;
  end

  always_comb begin
    ry_s = $signed({2'b00, oy}) + $signed({10'd0, cmd.tap_y}) - 13'sd0 - 13'(RADIUS);
    rx_s = $signed({2'b00, ox}) + $signed({10'd0, cmd.tap_x}) - 13'(RADIUS);
    if (ry_s < 0) ry = '0;
    else if (ry_s >= $signed({2'b00, h_eff})) ry = h_eff - 1'b1;
    else ry = ry_s[DIM_W-1:0];
    if (rx_s < 0) rx = '0;
    else if (rx_s >= $signed({2'b00, w_eff})) rx = w_eff - 1'b1;
    else rx = rx_s[DIM_W-1:0];
    diff = row - ry;
    if (DIM_W'(slot) >= diff) slot_rd = DIM_W'(slot) - diff;
    else if (DIM_W'(slot) + DIM_W'(SR) >= diff) slot_rd = DIM_W'(slot) + DIM_W'(SR) - diff;
    else slot_rd = DIM_W'(slot) + DIM_W'(2 * SR) - diff;
  end

  always_ff @(posedge clk) begin
    addr_a <= AW'(32'(slot_rd) * MAX_WIDTH + 32'(rx));
    wy_a   <= (cmd.tap_y >= TAP_W'(RADIUS)) ? 2'(cmd.tap_y - TAP_W'(RADIUS))
                                            : 2'(TAP_W'(RADIUS) - cmd.tap_y);
    wx_a   <= (cmd.tap_x >= TAP_W'(RADIUS)) ? 2'(cmd.tap_x - TAP_W'(RADIUS))
                                            : 2'(TAP_W'(RADIUS) - cmd.tap_x);
    rdata  <= mem[addr_a];
    wprod  <= 32'(weight[wy_a]) * 32'(weight[wx_a]);
    pr     <= 40'(rdata[23:16]) * 40'(wprod);
    pg     <= 40'(rdata[15:8]) * 40'(wprod);
    pb     <= 40'(rdata[7:0]) * 40'(wprod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= cmd.issue;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ar <= '0;
      ag <= '0;
      ab <= '0;
    end else if (vc) begin
      ar <= ar + 48'(pr);
      ag <= ag + 48'(pg);
      ab <= ab + 48'(pb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      out_data <= {round_sat(ar), round_sat(ag), round_sat(ab)};
      out_last <= last;
    end
  end
endmodule

// ===== rtl/core/gaussian_blur_window_filter.sv =====
// Gaussian blur window filter, top level. Depends on gbwf_pkg, gbwf_ctrl, gbwf_datapath.
// Sequence: an item with no result passes capture, position calculation and decision, with the
// calculation repeated when the position restarts; an item with a result then scans the window
// on the one shared multiply-accumulate unit, one row store word per cycle, drains and emits.
// Throughput: one item at a time; the result register lets the next item in.
// Reset: control, counters, configuration and output valid return to defaults; row store is not cleared.
module gaussian_blur_window_filter import gbwf_pkg::*; #(
  parameter int RADIUS    = RADIUS_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  input  logic        s_axis_tuser,   // is_padding
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
  output logic        m_axis_tlast
);
  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  gbwf_ctrl #(.RADIUS(RADIUS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gbwf_datapath #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   ({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
    .in_pad    (s_axis_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );
endmodule

// ===== rtl/core/gbwf_checker.sv =====
// Port-level checks of gaussian_blur_window_filter, bound to the top level.
// Depends on gaussian_blur_window_filter_assert.svh.
`include "gaussian_blur_window_filter_assert.svh"
module gbwf_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  `GBWF_ASSERT_NEXT(out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `GBWF_ASSERT_NEXT(one_item_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `GBWF_ASSERT_NEXT(no_instant_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))
  `GBWF_ASSERT_SAME(cfg_always_taken, cfg_valid, cfg_ready)
endmodule

bind gaussian_blur_window_filter gbwf_checker u_gbwf_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
